// ===== rtl/pvw_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Planar video write path package
// Request codes, register indexes and reset values shared by the write path.
// ----------------------------------------------------------------------------
package pvw_pkg;

    // Default number of byte locations in each of the four planes.
    localparam int unsigned PLANE_DEPTH_DEFAULT = 32768;

    localparam int unsigned NUM_PLANES = 4;

    typedef enum logic [1:0] {
        REQ_GC_WRITE  = 2'd0,
        REQ_SEQ_WRITE = 2'd1,
        REQ_MEM_READ  = 2'd2,
        REQ_MEM_WRITE = 2'd3
    } t_req;

    // Graphics controller register indexes.
    localparam logic [3:0] GC_SR_COLOR        = 4'd0;
    localparam logic [3:0] GC_SR_ENABLE       = 4'd1;
    localparam logic [3:0] GC_READ_MAP_SELECT = 4'd4;
    localparam logic [3:0] GC_PIXEL_MASK      = 4'd8;

    // Sequencer register indexes.
    localparam logic [3:0] SEQ_PLANE_ENABLE = 4'd2;

    localparam logic [7:0] BIT_MASK_RESET = 8'hFF;
    localparam logic [3:0] MAP_MASK_RESET = 4'hF;

endpackage
`default_nettype wire

// ===== rtl/planar_video_write_path_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Planar video write path unit
// Four-plane video memory behind graphics controller and sequencer registers.
// ----------------------------------------------------------------------------
// Usage: the host drives a bus access on i_req_type, i_reg_index, i_address
// and i_data and raises start; the access is taken at a clock edge where
// start is high and busy is low. Register writes load Set/Reset, Enable
// Set/Reset, Read Map Select, Bit Mask (controller) or Map Mask (sequencer).
// A memory read loads the four plane latches and returns the selected plane's
// byte on o_read_data with o_read_valid high for exactly one cycle, in the
// cycle after the read is taken. A memory write (write mode 0, replace) merges
// Set/Reset, CPU data and the latches under the Bit Mask and writes the
// planes enabled by the Map Mask.
// Throughput: one access per cycle of any type, in any order, while busy is
// low. The plane store is one synchronous RAM with a registered read; a write
// right after a read takes the latches forwarded from the RAM output register.
// Reset: after i_rst_n is released the RAM is cleared one word per cycle,
// covering all PLANE_DEPTH words, with busy high. Results cannot be stalled by
// the receiver; each strobe is a transfer.
// ----------------------------------------------------------------------------
module planar_video_write_path_unit #(
    parameter int unsigned PLANE_DEPTH = pvw_pkg::PLANE_DEPTH_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [3:0]  i_reg_index,
    input  wire logic [14:0] i_address,
    input  wire logic [7:0]  i_data,
    output logic [7:0]       o_read_data,
    output logic             o_read_valid
);

    localparam int unsigned AW     = $clog2(PLANE_DEPTH);
    localparam int unsigned ModW   = 20;
    localparam int unsigned WordW  = 8 * pvw_pkg::NUM_PLANES;

    logic [WordW-1:0] r_mem [PLANE_DEPTH];

    logic                           r_clearing;
    logic [AW-1:0]                  r_clr_addr;
    logic                           r_rd_pend;
    logic [1:0]                     r_rd_sel;
    logic [WordW-1:0]               r_q;
    logic [WordW-1:0]               r_latches;
    logic [pvw_pkg::NUM_PLANES-1:0] r_sr_color;
    logic [pvw_pkg::NUM_PLANES-1:0] r_sr_en;
    logic [1:0]                     r_rd_map;
    logic [7:0]                     r_bit_mask;
    logic [pvw_pkg::NUM_PLANES-1:0] r_map_mask;

    logic                           accept;
    pvw_pkg::t_req                  req;
    logic [ModW-1:0]                addr_work;
    logic [AW-1:0]                  addr_idx;
    logic [WordW-1:0]               n_latches;
    logic [WordW-1:0]               wr_word;
    logic                           mem_we;
    logic [pvw_pkg::NUM_PLANES-1:0] mem_be;
    logic [WordW-1:0]               mem_wd;
    logic [AW-1:0]                  mem_idx;
    logic                           mem_re;

    assign busy   = r_clearing;
    assign accept = start && !busy;
    assign req    = pvw_pkg::t_req'(i_req_type);

    // The address wraps modulo the plane depth; four conditional subtractions of
    // scaled depths reduce it while the quotient is below sixteen.
    always_comb begin
        addr_work = ModW'(i_address);
        for (int k = 3; k >= 0; k--) begin
            if (addr_work >= (ModW'(PLANE_DEPTH) << k)) begin
                addr_work = addr_work - (ModW'(PLANE_DEPTH) << k);
            end
        end
        addr_idx = addr_work[AW-1:0];
    end

    // A read taken in the previous cycle has its word in r_q, not yet in
    // the latch register.
    assign n_latches = r_rd_pend ? r_q : r_latches;

    always_comb begin
        logic [7:0] src;
        logic [7:0] old;
        wr_word = '0;
        for (int p = 0; p < pvw_pkg::NUM_PLANES; p++) begin
            old = n_latches[8*p +: 8];
            src = r_sr_en[p] ? {8{r_sr_color[p]}} : i_data;
            wr_word[8*p +: 8] = (src & r_bit_mask) | (old & ~r_bit_mask);
        end
    end

    assign mem_we  = r_clearing || (accept && req == pvw_pkg::REQ_MEM_WRITE);
    assign mem_re  = accept && req == pvw_pkg::REQ_MEM_READ;
    assign mem_be  = r_clearing ? '1 : r_map_mask;
    assign mem_wd  = r_clearing ? '0 : wr_word;
    assign mem_idx = r_clearing ? r_clr_addr : addr_idx;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            for (int p = 0; p < pvw_pkg::NUM_PLANES; p++) begin
                if (mem_be[p]) begin
                    r_mem[mem_idx][8*p +: 8] <= mem_wd[8*p +: 8];
                end
            end
        end
        if (mem_re) begin
            r_q <= r_mem[addr_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_rd_pend  <= 1'b0;
            r_rd_sel   <= '0;
            r_latches  <= '0;
            r_sr_color <= '0;
            r_sr_en    <= '0;
            r_rd_map   <= '0;
            r_bit_mask <= pvw_pkg::BIT_MASK_RESET;
            r_map_mask <= pvw_pkg::MAP_MASK_RESET;
        end else begin
            r_latches <= n_latches;
            r_rd_pend <= mem_re;
            if (mem_re) begin
                r_rd_sel <= r_rd_map;
            end
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(PLANE_DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (accept && req == pvw_pkg::REQ_GC_WRITE) begin
                unique case (i_reg_index)
                    pvw_pkg::GC_SR_COLOR:        r_sr_color <= i_data[3:0];
                    pvw_pkg::GC_SR_ENABLE:       r_sr_en    <= i_data[3:0];
                    pvw_pkg::GC_READ_MAP_SELECT: r_rd_map   <= i_data[1:0];
                    pvw_pkg::GC_PIXEL_MASK:      r_bit_mask <= i_data;
                    default: ;
                endcase
            end
            if (accept && req == pvw_pkg::REQ_SEQ_WRITE
                    && i_reg_index == pvw_pkg::SEQ_PLANE_ENABLE) begin
                r_map_mask <= i_data[3:0];
            end
        end
    end

    assign o_read_valid = r_rd_pend;
    assign o_read_data  = r_q[{r_rd_sel, 3'b000} +: 8];

    // A result strobe follows exactly one taken memory read.
    a_strobe_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_read_valid |-> $past(start && !busy && i_req_type == pvw_pkg::REQ_MEM_READ))
        else $error("read strobe without a preceding memory read");

    // The clearing pass writes zeros to every plane and returns no data.
    a_clear_writes_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> (mem_we && mem_be == '1 && mem_wd == '0 && !o_read_valid))
        else $error("clearing pass does not write a zero word");

    // The clearing pass ends only after the last word has been written.
    a_clear_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clearing) |-> $past(r_clr_addr) == AW'(PLANE_DEPTH - 1))
        else $error("clearing pass ended early");

    // A write taken right after a read merges with the freshly read word.
    a_latch_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> n_latches == r_q)
        else $error("latches not forwarded from read data");

endmodule
`default_nettype wire
